// ===== src/escv_pkg.sv =====
// Package for the extrusion segment corner generator.
// Holds the fixed-point format constants, the pipeline payload types and the corner table.
// No dependencies.
`default_nettype none

package escv_pkg;

    // Field widths and fixed-point formats
    localparam int CoordW        = 32;
    localparam int BeadW         = 24;
    localparam int CoordFracBits = 16;
    localparam int BeadFracBits  = 16;
    localparam int DirFracBits   = 30;

    // Delta magnitude, scaled magnitude, sum, square root, quotient, dividend, product, offset and corner widths
    localparam int MagW   = CoordW + 1;
    localparam int ScaleW = 31;
    localparam int SumW   = 64;
    localparam int RootW  = 32;
    localparam int QuotW  = 31;
    localparam int DivW   = 62;
    localparam int ProdW  = 57;
    localparam int OffW   = 34;
    localparam int CornW  = 36;

    // Corner order: bit k set when corner k uses the height offset,
    // and when corner k subtracts its offset.
    localparam logic [7:0] CornerUsesHeight = 8'b0101_1010;
    localparam logic [7:0] CornerMinus      = 8'b0110_0110;
    localparam logic [2:0] CornerLast       = 3'd7;

    // Move payload that travels along the pipeline
    typedef struct packed {
        logic [5:0][CoordW-1:0] pt;
        logic [BeadW-1:0]       bw;
        logic [BeadW-1:0]       bh;
        logic [2:0]             neg;
        logic                   degen;
    } t_item;

    // One step of the square root pipeline
    typedef struct packed {
        logic [SumW-1:0]            rem;
        logic [RootW-1:0]           root;
        logic [2:0][ScaleW-1:0]     ms;
    } t_sq;

    // One step of the divider pipeline, three lanes sharing the divisor
    typedef struct packed {
        logic [2:0][DivW-1:0]   rem;
        logic [2:0][QuotW-1:0]  q;
        logic [RootW-1:0]       len;
    } t_dv;

endpackage

`default_nettype wire

// ===== src/extrusion_segment_cuboid_vertices.sv =====
// Extrusion segment corner generator: eight prism corners per straight move.
// Each accepted move passes through the delta, scaling, square root, divider and offset
// stages, then eight corners follow on consecutive cycles. Throughput is set by the single
// corner output port: busy goes high after each accepted beat and blocks new moves.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline advances every cycle.
`default_nettype none

module extrusion_segment_cuboid_vertices
    import escv_pkg::*;
#(
    parameter int COORD_FRAC_BITS = CoordFracBits
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [CoordW-1:0] i_start_x,
    input  wire logic signed [CoordW-1:0] i_start_y,
    input  wire logic signed [CoordW-1:0] i_start_z,
    input  wire logic signed [CoordW-1:0] i_end_x,
    input  wire logic signed [CoordW-1:0] i_end_y,
    input  wire logic signed [CoordW-1:0] i_end_z,
    input  wire logic [BeadW-1:0]         i_bead_width,
    input  wire logic [BeadW-1:0]         i_bead_height,
    output logic                          o_valid,
    output logic [2:0]                    o_corner_index,
    output logic signed [CoordW-1:0]      o_corner_x,
    output logic signed [CoordW-1:0]      o_corner_y,
    output logic signed [CoordW-1:0]      o_corner_z,
    output logic                          o_degenerate,
    output logic                          o_last_corner
);

    localparam int OffShift = DirFracBits + 1 + BeadFracBits - COORD_FRAC_BITS;
    localparam int SqSteps  = RootW;
    localparam int DvSteps  = QuotW;

    // Input throttle: a move is accepted only while busy is low
    logic [2:0] r_gap;
    logic       accept;

    assign busy   = (r_gap != 3'd0);
    assign accept = start && !busy;

    // Stage 1: deltas as sign and magnitude
    t_item               n1_item;
    logic [2:0][MagW-1:0] n1_mag;
    t_item               r1_item;
    logic [2:0][MagW-1:0] r1_mag;
    logic                r1_v;

    always_comb begin
        logic signed [MagW-1:0] diff;
        n1_item.pt    = {i_end_z, i_end_y, i_end_x, i_start_z, i_start_y, i_start_x};
        n1_item.bw    = i_bead_width;
        n1_item.bh    = i_bead_height;
        n1_item.degen = 1'b0;
        for (int i = 0; i < 3; i++) begin
            diff = {n1_item.pt[3+i][CoordW-1], n1_item.pt[3+i]}
                 - {n1_item.pt[i][CoordW-1], n1_item.pt[i]};
            n1_item.neg[i] = diff[MagW-1];
            n1_mag[i]      = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);
        end
    end

    // Stage 2: leading-one position of the largest magnitude
    logic [MagW-1:0]      n2_or;
    logic [5:0]           n2_pos;
    t_item                n2_item;
    t_item                r2_item;
    logic [2:0][MagW-1:0] r2_mag;
    logic [5:0]           r2_pos;
    logic                 r2_v;

    always_comb begin
        n2_or  = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n2_pos = 6'd0;
        for (int b = 0; b < MagW; b++) begin
            if (n2_or[b]) begin
                n2_pos = 6'(b);
            end
        end
        n2_item       = r1_item;
        n2_item.degen = (n2_or == '0);
    end

    // Stage 3: scale so the largest magnitude lies in [2^30, 2^31)
    logic [2:0][ScaleW-1:0] n3_ms;
    t_item                  r3_item;
    logic [2:0][ScaleW-1:0] r3_ms;
    logic                   r3_v;

    always_comb begin
        logic [62:0] wide;
        for (int i = 0; i < 3; i++) begin
            if (r2_pos >= 6'(ScaleW - 1)) begin
                wide = {30'd0, r2_mag[i]} >> (r2_pos - 6'(ScaleW - 1));
            end else begin
                wide = {30'd0, r2_mag[i]} << (6'(ScaleW - 1) - r2_pos);
            end
            n3_ms[i] = wide[ScaleW-1:0];
        end
    end

    // Stage 4: squares of the scaled magnitudes
    t_item                    r4_item;
    logic [2:0][ScaleW-1:0]   r4_ms;
    logic [2:0][2*ScaleW-1:0] r4_sq;
    logic                     r4_v;

    // Square root pipeline, one root bit per stage; stage 0 holds the sum
    t_sq   r_sq   [0:SqSteps];
    t_item r_sqit [0:SqSteps];
    logic  [SqSteps:0] r_sqv;
    t_sq   n_sq   [1:SqSteps];

    always_comb begin
        logic [65:0] trial;
        for (int k = 1; k <= SqSteps; k++) begin
            n_sq[k] = r_sq[k-1];
            trial   = ({34'd0, r_sq[k-1].root} << (SqSteps - k + 1))
                    | (66'd1 << (2 * (SqSteps - k)));
            if ({2'b00, r_sq[k-1].rem} >= trial) begin
                n_sq[k].rem  = SumW'({2'b00, r_sq[k-1].rem} - trial);
                n_sq[k].root = r_sq[k-1].root | (RootW'(1) << (SqSteps - k));
            end
        end
    end

    // Divider pipeline, one quotient bit per stage for three lanes; stage 0 is loaded
    t_dv   r_dv   [0:DvSteps];
    t_item r_dvit [0:DvSteps];
    logic  [DvSteps:0] r_dvv;
    t_dv   n_dv   [1:DvSteps];
    t_dv   n_dv0;

    always_comb begin
        logic [DivW:0] trial;
        n_dv0.len = r_sq[SqSteps].root;
        for (int i = 0; i < 3; i++) begin
            n_dv0.rem[i] = ({31'd0, r_sq[SqSteps].ms[i]} << DirFracBits)
                         + DivW'(r_sq[SqSteps].root >> 1);
            n_dv0.q[i]   = '0;
        end
        for (int k = 1; k <= DvSteps; k++) begin
            n_dv[k] = r_dv[k-1];
            trial   = {31'd0, r_dv[k-1].len} << (DvSteps - k);
            for (int i = 0; i < 3; i++) begin
                if ({1'b0, r_dv[k-1].rem[i]} >= trial) begin
                    n_dv[k].rem[i] = DivW'({1'b0, r_dv[k-1].rem[i]} - trial);
                    n_dv[k].q[i]   = r_dv[k-1].q[i] | (QuotW'(1) << (DvSteps - k));
                end
            end
        end
    end

    // Stage U: direction magnitudes and the products for the up vector
    logic [2:0][QuotW-1:0] nu_d;
    t_item                 ru_item;
    logic [2:0][QuotW-1:0] ru_d;
    logic [3:0][61:0]      ru_p;
    logic                  ru_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nu_d[i] = r_dvit[DvSteps].degen ? '0 : r_dv[DvSteps].q[i];
        end
    end

    // Stage V: up vector rounded to Q3.30, left vector from the direction
    logic [2:0][32:0] nv_up;
    logic [2:0]       nv_upneg;
    logic [62:0]      nv_ysum;
    t_item            rv_item;
    logic [2:0][32:0] rv_up;
    logic [2:0]       rv_upneg;
    logic [QuotW-1:0] rv_l0;
    logic [QuotW-1:0] rv_l2;
    logic             rv_l0neg;
    logic             rv_l2neg;
    logic             rv_v;

    always_comb begin
        nv_ysum     = 63'(ru_p[1]) + 63'(ru_p[2]) + (63'd1 << (DirFracBits - 1));
        nv_up[0]    = 33'((63'(ru_p[0]) + (63'd1 << (DirFracBits - 1))) >> DirFracBits);
        nv_up[1]    = 33'(nv_ysum >> DirFracBits);
        nv_up[2]    = 33'((63'(ru_p[3]) + (63'd1 << (DirFracBits - 1))) >> DirFracBits);
        nv_upneg[0] = !(ru_item.neg[0] ^ ru_item.neg[1]);
        nv_upneg[1] = 1'b0;
        nv_upneg[2] = !(ru_item.neg[1] ^ ru_item.neg[2]);
    end

    // Stage W: bead size times vector component
    t_item                 rw_item;
    logic [1:0][ProdW-1:0] rw_pw;
    logic [2:0][ProdW-1:0] rw_ph;
    logic [1:0]            rw_wneg;
    logic [2:0]            rw_hneg;
    logic                  rw_v;

    // Stage X: offsets rescaled to the coordinate format
    t_item              rx_item;
    logic [1:0][OffW-1:0] rx_ow;
    logic [2:0][OffW-1:0] rx_oh;
    logic [1:0]         rx_wneg;
    logic [2:0]         rx_hneg;
    logic               rx_v;
    logic [1:0][OffW-1:0] nx_ow;
    logic [2:0][OffW-1:0] nx_oh;

    always_comb begin
        logic [ProdW-1:0] t;
        for (int i = 0; i < 2; i++) begin
            t        = (rw_pw[i] + (ProdW'(1) << (OffShift - 1))) >> OffShift;
            nx_ow[i] = t[OffW-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            t        = (rw_ph[i] + (ProdW'(1) << (OffShift - 1))) >> OffShift;
            nx_oh[i] = t[OffW-1:0];
        end
    end

    // Corner buffer and sequencer
    t_item                r_buf;
    logic [2:0][OffW-1:0] r_bow;
    logic [2:0][OffW-1:0] r_boh;
    logic [2:0]           r_bwneg;
    logic [2:0]           r_bhneg;
    logic                 r_act;
    logic [2:0]           r_cnt;
    logic [2:0][CoordW-1:0] n_corner;

    always_comb begin
        logic              use_h;
        logic              sub;
        logic [OffW-1:0]   mag;
        logic              ng;
        logic signed [CornW-1:0] sum;
        logic signed [CornW-1:0] off;
        logic [CoordW-1:0] base;
        use_h = CornerUsesHeight[r_cnt];
        sub   = CornerMinus[r_cnt];
        for (int i = 0; i < 3; i++) begin
            base = r_cnt[2] ? r_buf.pt[3+i] : r_buf.pt[i];
            mag  = use_h ? r_boh[i] : r_bow[i];
            ng   = (use_h ? r_bhneg[i] : r_bwneg[i]) ^ sub;
            off  = ng ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
            sum  = $signed({{(CornW-CoordW){base[CoordW-1]}}, base}) + off;
            if (sum > $signed(CornW'(2147483647))) begin
                n_corner[i] = 32'h7FFF_FFFF;
            end else if (sum < -$signed(CornW'(64'h8000_0000))) begin
                n_corner[i] = 32'h8000_0000;
            end else begin
                n_corner[i] = sum[CoordW-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= 3'd0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_sqv   <= '0;
            r_dvv   <= '0;
            ru_v    <= 1'b0;
            rv_v    <= 1'b0;
            rw_v    <= 1'b0;
            rx_v    <= 1'b0;
            r_act   <= 1'b0;
            r_cnt   <= 3'd0;
            o_valid <= 1'b0;
        end else begin
            r_gap   <= accept ? 3'd7 : (busy ? r_gap - 3'd1 : 3'd0);
            r1_v    <= accept;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_sqv   <= {r_sqv[SqSteps-1:0], r4_v};
            r_dvv   <= {r_dvv[DvSteps-1:0], r_sqv[SqSteps]};
            ru_v    <= r_dvv[DvSteps];
            rv_v    <= ru_v;
            rw_v    <= rv_v;
            rx_v    <= rw_v;
            o_valid <= r_act;
            if (rx_v) begin
                r_act <= 1'b1;
                r_cnt <= 3'd0;
            end else if (r_act) begin
                r_act <= (r_cnt != CornerLast);
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r1_item <= n1_item;
        r1_mag  <= n1_mag;

        r2_item <= n2_item;
        r2_mag  <= r1_mag;
        r2_pos  <= n2_pos;

        r3_item <= r2_item;
        r3_ms   <= n3_ms;

        r4_item <= r3_item;
        r4_ms   <= r3_ms;
        for (int i = 0; i < 3; i++) begin
            r4_sq[i] <= (2*ScaleW)'(r3_ms[i]) * (2*ScaleW)'(r3_ms[i]);
        end

        r_sqit[0]     <= r4_item;
        r_sq[0].rem   <= SumW'(r4_sq[0]) + SumW'(r4_sq[1]) + SumW'(r4_sq[2]);
        r_sq[0].root  <= '0;
        r_sq[0].ms    <= r4_ms;
        for (int k = 1; k <= SqSteps; k++) begin
            r_sq[k]   <= n_sq[k];
            r_sqit[k] <= r_sqit[k-1];
        end

        r_dv[0]   <= n_dv0;
        r_dvit[0] <= r_sqit[SqSteps];
        for (int k = 1; k <= DvSteps; k++) begin
            r_dv[k]   <= n_dv[k];
            r_dvit[k] <= r_dvit[k-1];
        end

        ru_item <= r_dvit[DvSteps];
        ru_d    <= nu_d;
        ru_p[0] <= 62'(nu_d[0]) * 62'(nu_d[1]);
        ru_p[1] <= 62'(nu_d[0]) * 62'(nu_d[0]);
        ru_p[2] <= 62'(nu_d[2]) * 62'(nu_d[2]);
        ru_p[3] <= 62'(nu_d[1]) * 62'(nu_d[2]);

        rv_item  <= ru_item;
        rv_up    <= nv_up;
        rv_upneg <= nv_upneg;
        rv_l0    <= ru_d[2];
        rv_l0neg <= ru_item.neg[2];
        rv_l2    <= ru_d[0];
        rv_l2neg <= !ru_item.neg[0];

        rw_item    <= rv_item;
        rw_pw[0]   <= ProdW'(rv_item.bw) * ProdW'(rv_l0);
        rw_pw[1]   <= ProdW'(rv_item.bw) * ProdW'(rv_l2);
        rw_wneg    <= {rv_l2neg, rv_l0neg};
        for (int i = 0; i < 3; i++) begin
            rw_ph[i] <= ProdW'(rv_item.bh) * ProdW'(rv_up[i]);
        end
        rw_hneg    <= rv_upneg;

        rx_item <= rw_item;
        rx_ow   <= nx_ow;
        rx_oh   <= nx_oh;
        rx_wneg <= rw_wneg;
        rx_hneg <= rw_hneg;

        if (rx_v) begin
            r_buf   <= rx_item;
            r_bow   <= {rx_ow[1], {OffW{1'b0}}, rx_ow[0]};
            r_boh   <= rx_oh;
            r_bwneg <= {rx_wneg[1], 1'b0, rx_wneg[0]};
            r_bhneg <= rx_hneg;
        end

        o_corner_index <= r_cnt;
        o_corner_x     <= n_corner[0];
        o_corner_y     <= n_corner[1];
        o_corner_z     <= n_corner[2];
        o_degenerate   <= r_buf.degen;
        o_last_corner  <= (r_cnt == CornerLast);
    end

endmodule

`default_nettype wire
